// ===== rtl/plp_pkg.sv =====
`default_nettype none

package plp_pkg;

  // Fixed field widths of the command and result transactions.
  localparam int unsigned POS_W         = 5;
  localparam int unsigned HANDLE_W      = 16;
  localparam int unsigned PLATE_W       = 56;
  localparam int unsigned FOUND_W       = 4;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned PLATE_CHARS   = 7;
  localparam int unsigned CAPACITY_DEF  = 16;

  // Command codes; the fourth code is unused and is rejected.
  typedef enum logic [1:0] {
    CMD_INSERT       = 2'd0,
    CMD_REMOVE       = 2'd1,
    CMD_REMOVE_PLATE = 2'd2
  } cmd_t;

  // Status codes of a result.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_REJECT    = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_MATCH
  } op_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [POS_W-1:0]    position;
    logic [HANDLE_W-1:0] vehicle_handle;
    logic [PLATE_W-1:0]  plate;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FOUND_W-1:0] found_position;
    logic [COUNT_W-1:0] entry_count;
  } rsp_item_t;

  // Control and data sent from the sequencer to the cells.
  typedef struct packed {
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
    logic [PLATE_W-1:0]  plate;
  } bcast_t;

  // Keep the bytes up to the first zero byte, reading from the high byte.
  function automatic logic [PLATE_W-1:0] plate_norm(input logic [PLATE_W-1:0] p);
    logic [63:0] wide;
    logic [63:0] r;
    logic        stop;
    logic [7:0]  b;
    wide = 64'(p);
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < PLATE_CHARS; i++) begin
      b = wide[(PLATE_CHARS-1-i)*8 +: 8];
      if (b == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[(PLATE_CHARS-1-i)*8 +: 8] = b;
      end
    end
    return r[PLATE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/positional_list_with_key_removal.sv =====
`default_nettype none

// Ordered list of up to CAPACITY vehicle entries (handle and plate).
// Commands arrive on the cmd channel (valid/ready) and each gives exactly
// one result on the rsp channel (valid/ready): status, matched position
// and the entry count after the command.
// Insert and remove by position go from acceptance through the apply state
// to the result register; remove by plate first passes a match state in
// which every cell of the chain compares its stored plate with the key and
// registers a match bit.
// One command is in work at a time, so a new command is taken only when
// the previous result has been delivered or is taken in the same cycle.
// A stalled receiver holds the result in the output register and the
// cmd channel stays not ready until it is taken.
// Synchronous reset empties the list and clears all handshake state;
// entry contents are not cleared, since only occupied entries are read.

module positional_list_with_key_removal #(
  parameter int unsigned CAPACITY = plp_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire plp_pkg::cmd_item_t cmd_data,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output plp_pkg::rsp_item_t      rsp_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > plp_pkg::POS_W) ? CW : plp_pkg::POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_t;

  state_t                        state;
  logic [1:0]                    cmd_q;
  logic [PW-1:0]                 pos_q;
  logic [plp_pkg::HANDLE_W-1:0]  handle_q;
  logic [plp_pkg::PLATE_W-1:0]   key_q;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;

  plp_pkg::bcast_t               bcast;
  logic [CW-1:0]                 bpos;
  logic [PW-1:0]                 count_ext;
  logic                          ins_ok;
  logic                          rem_ok;
  logic                          any_match;
  logic [CW-1:0]                 first;
  logic [1:0]                    status_next;
  logic [CW-1:0]                 found_next;

  logic [plp_pkg::HANDLE_W-1:0]  cell_handle [CAPACITY];
  logic [plp_pkg::PLATE_W-1:0]   cell_plate  [CAPACITY];
  logic [CAPACITY-1:0]           cell_match;

  assign cmd_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);

  // Range checks against the current fill.
  assign count_ext = PW'(count);
  assign ins_ok    = (count < CW'(CAPACITY)) && (pos_q <= count_ext);
  assign rem_ok    = pos_q < count_ext;

  // Lowest cell that reported a match.
  always_comb begin
    any_match = 1'b0;
    first     = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        any_match = 1'b1;
        first     = CW'(i);
      end
    end
  end

  // Operation for the chain, status and new count.
  always_comb begin
    bcast.op     = plp_pkg::OP_NONE;
    bcast.handle = handle_q;
    bcast.plate  = key_q;
    bpos         = pos_q[CW-1:0];
    status_next  = plp_pkg::ST_REJECT;
    found_next   = '0;
    count_next   = count;
    if (state == S_MATCH) begin
      bcast.op = plp_pkg::OP_MATCH;
    end else if (state == S_APPLY) begin
      unique case (cmd_q)
        plp_pkg::CMD_INSERT: begin
          if (ins_ok) begin
            bcast.op    = plp_pkg::OP_INSERT;
            status_next = plp_pkg::ST_DONE;
            count_next  = count + CW'(1);
          end
        end
        plp_pkg::CMD_REMOVE: begin
          if (rem_ok) begin
            bcast.op    = plp_pkg::OP_REMOVE;
            status_next = plp_pkg::ST_DONE;
            count_next  = count - CW'(1);
          end
        end
        plp_pkg::CMD_REMOVE_PLATE: begin
          status_next = plp_pkg::ST_NOT_FOUND;
          if (any_match) begin
            bcast.op    = plp_pkg::OP_REMOVE;
            bpos        = first;
            status_next = plp_pkg::ST_DONE;
            found_next  = first;
            count_next  = count - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer, count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cmd_q    <= cmd_data.cmd;
            pos_q    <= PW'(cmd_data.position);
            handle_q <= cmd_data.vehicle_handle;
            key_q    <= plp_pkg::plate_norm(cmd_data.plate);
            state    <= (cmd_data.cmd == plp_pkg::CMD_REMOVE_PLATE) ? S_MATCH : S_APPLY;
          end
        end
        S_MATCH: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          count                   <= count_next;
          rsp_valid               <= 1'b1;
          rsp_data.status         <= status_next;
          rsp_data.found_position <= plp_pkg::FOUND_W'(found_next);
          rsp_data.entry_count    <= plp_pkg::COUNT_W'(count_next);
          state                   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Chain of entry cells, each wired to its neighbors; the end cells see zero beyond the chain.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [plp_pkg::HANDLE_W-1:0] lh;
    logic [plp_pkg::PLATE_W-1:0]  lp;
    logic [plp_pkg::HANDLE_W-1:0] rh;
    logic [plp_pkg::PLATE_W-1:0]  rp;

    if (g == 0) begin : g_left_end
      assign lh = '0;
      assign lp = '0;
    end else begin : g_left
      assign lh = cell_handle[g-1];
      assign lp = cell_plate[g-1];
    end

    if (g == CAPACITY - 1) begin : g_right_end
      assign rh = '0;
      assign rp = '0;
    end else begin : g_right
      assign rh = cell_handle[g+1];
      assign rp = cell_plate[g+1];
    end

    plp_cell #(
      .INDEX (g),
      .CW    (CW)
    ) u_cell (
      .clk          (clk),
      .bcast        (bcast),
      .pos          (bpos),
      .count        (count),
      .left_handle  (lh),
      .left_plate   (lp),
      .right_handle (rh),
      .right_plate  (rp),
      .handle       (cell_handle[g]),
      .plate        (cell_plate[g]),
      .match        (cell_match[g])
    );
  end

  // The fill never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A result never appears in the cycle after a command is taken.
  a_no_early_rsp: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !rsp_valid)
    else $error("result too early");

  // A done result always changes the count, any other result never does.
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |->
      ((rsp_data.status == plp_pkg::ST_DONE) == (count != $past(count))))
    else $error("count change does not agree with status");

  // A matched position is reported only with a done status.
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_data.status != plp_pkg::ST_DONE)) |->
      (rsp_data.found_position == '0))
    else $error("found position set on a failed command");

endmodule

`default_nettype wire

// ===== rtl/plp_cell.sv =====
`default_nettype none

module plp_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 5
) (
  input  wire logic                          clk,
  input  wire plp_pkg::bcast_t               bcast,
  input  wire logic [CW-1:0]                 pos,
  input  wire logic [CW-1:0]                 count,
  input  wire logic [plp_pkg::HANDLE_W-1:0]  left_handle,
  input  wire logic [plp_pkg::PLATE_W-1:0]   left_plate,
  input  wire logic [plp_pkg::HANDLE_W-1:0]  right_handle,
  input  wire logic [plp_pkg::PLATE_W-1:0]   right_plate,
  output logic [plp_pkg::HANDLE_W-1:0]       handle,
  output logic [plp_pkg::PLATE_W-1:0]        plate,
  output logic                               match
);

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  // Shift, load or compare depending on the broadcast operation.
  always_ff @(posedge clk) begin
    unique case (bcast.op)
      plp_pkg::OP_INSERT: begin
        if (IDX > pos) begin
          handle <= left_handle;
          plate  <= left_plate;
        end else if (IDX == pos) begin
          handle <= bcast.handle;
          plate  <= bcast.plate;
        end
      end
      plp_pkg::OP_REMOVE: begin
        if (IDX >= pos) begin
          handle <= right_handle;
          plate  <= right_plate;
        end
      end
      plp_pkg::OP_MATCH: begin
        match <= (plate == bcast.plate) && (IDX < count);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
